// ----- design/afcs_pkg.sv -----
`default_nettype none
package afcs_pkg;
  localparam int HistDepth = 64;
  localparam int MaxFrames = 16;
  localparam int HistW = 6;
  localparam int SlotW = 4;
  localparam int TagW = 31;
  localparam int ScoreUnit = 1000;
  localparam logic [6:0] MinDepthReset = 7'd100;
  localparam logic [15:0] InertiaMax = 16'hFFFF;
  localparam logic OP_REQ = 1'b0;
  localparam logic OP_DROP = 1'b1;

  typedef logic [TagW-1:0] tag_t;
endpackage
`default_nettype wire

// ----- design/adaptive_frame_cache_sizer.sv -----
`default_nettype none
// A hit ends the search at the matching tag read; a miss searches the tags, then the history
// ring, and a number found in the history waits on the divide before the score update.
// A drop event updates score and capacity, or goes straight to the result on an empty store.
// One item at a time: the next transfer is accepted only after the result is registered;
// a stalled result delays both.
// Reset clears counts, heads, score, capacity; inertia goes to 1, minimum depth to 100.
module adaptive_frame_cache_sizer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        opcode,
  input  wire logic [30:0] frame_number,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             hit,
  output logic [3:0]       slot,
  output logic             stored,
  output logic [6:0]       history_depth,
  output logic [4:0]       capacity
);
  localparam logic [3:0] S_IDLE = 4'd0, S_TRD = 4'd1, S_TCMP = 4'd2, S_RRD = 4'd3,
                         S_RCMP = 4'd4, S_MUL = 4'd5, S_DIV = 4'd6, S_WAITD = 4'd7,
                         S_SCORE = 4'd8, S_RESZ = 4'd9, S_STORE = 4'd10, S_OUT = 4'd11,
                         S_PUSH = 4'd12;

  // Memories
  afcs_pkg::tag_t tag_mem [afcs_pkg::MaxFrames];
  afcs_pkg::tag_t ring_mem [afcs_pkg::HistDepth];
  afcs_pkg::tag_t tag_rd, ring_rd;
  logic [3:0] tag_ra;
  logic [5:0] ring_ra;

  logic [3:0]  state;
  logic        op;
  afcs_pkg::tag_t tag;
  logic [6:0]  rcount;
  logic [5:0]  rhead;
  logic [4:0]  fcount;
  logic [3:0]  fhead;
  logic [4:0]  cap;
  logic signed [31:0] score;
  logic [15:0] inertia;
  logic [6:0]  mindep;
  logic [6:0]  idx;
  logic [22:0] divisor;
  logic        div_start, div_done;
  logic [9:0]  quo;
  logic        r_hit, r_stored;
  logic [3:0]  r_slot;
  logic [6:0]  r_depth;
  logic        pend;

  logic signed [32:0] score_sum;
  logic signed [31:0] score_sat;
  logic [21:0] qk;
  logic [4:0]  cap_next;

  always_ff @(posedge clk) begin
    tag_rd  <= tag_mem[tag_ra];
    ring_rd <= ring_mem[ring_ra];
  end

  afcs_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .divisor(divisor),
    .done(div_done), .quotient(quo)
  );

  assign in_stall = (state != S_IDLE) || pend;
  assign tag_ra = 4'(fhead + idx[3:0]);
  assign ring_ra = rhead - 6'(idx) - 6'd1;
  assign div_start = (state == S_DIV);

  // Score update: add quotient or subtract one unit, saturating
  assign score_sum = (op == afcs_pkg::OP_DROP) ? (33'(score) - 33'sd1000)
                                               : (33'(score) + $signed({23'd0, quo}));
  assign score_sat = (score_sum > 33'sh7FFFFFFF) ? 32'sh7FFFFFFF :
                     (score_sum < -33'sh80000000) ? 32'sh80000000 : score_sum[31:0];

  // Capacity from score: score/1000 via reciprocal multiply (score < 2^31)
  always_comb begin
    logic [63:0] p;
    logic [31:0] q;
    p = 64'(score[30:0]) * 64'd2199023256;
    q = 32'(p >> 41);
    qk = q[21:0];
    cap_next = 5'd0;
    if (!score[31] && score != 0 && {10'd0, qk} >= 32'(mindep))
      cap_next = (qk > 22'd16) ? 5'd16 : qk[4:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; pend <= 1'b0; out_valid <= 1'b0;
      rcount <= '0; rhead <= '0; fcount <= '0; fhead <= '0; cap <= '0;
      score <= '0; inertia <= 16'd1; mindep <= afcs_pkg::MinDepthReset;
    end else begin
      if (pend && !(out_valid && out_stall)) begin
        pend <= 1'b0; out_valid <= 1'b1;
        hit <= r_hit; slot <= r_slot; stored <= r_stored;
        history_depth <= r_depth; capacity <= cap;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: if (in_valid && !in_stall) begin
          op <= opcode; tag <= frame_number; idx <= '0;
          r_hit <= 1'b0; r_slot <= '0; r_stored <= 1'b0; r_depth <= '0;
          if (opcode == afcs_pkg::OP_DROP) state <= (fcount != 0) ? S_SCORE : S_OUT;
          else state <= (fcount != 0) ? S_TRD : S_RRD;
        end
        S_TRD: state <= S_TCMP;
        S_TCMP: if (tag_rd == tag) begin
          r_hit <= 1'b1; r_stored <= 1'b1; r_slot <= tag_ra; state <= S_OUT;
        end else if (7'(idx) + 7'd1 >= 7'(fcount)) begin
          idx <= '0; state <= (rcount != 0) ? S_RRD : S_PUSH;
        end else begin
          idx <= idx + 7'd1; state <= S_TRD;
        end
        S_RRD: state <= (rcount == 0) ? S_PUSH : S_RCMP;
        S_RCMP: if (ring_rd == tag) begin
          r_depth <= idx + 7'd1; state <= S_MUL;
        end else if (idx + 7'd1 >= rcount) begin
          state <= S_PUSH;
        end else begin
          idx <= idx + 7'd1; state <= S_RRD;
        end
        S_PUSH: begin
          ring_mem[rhead] <= tag; rhead <= rhead + 6'd1;
          if (rcount < 7'd64) rcount <= rcount + 7'd1;
          state <= S_STORE;
        end
        S_MUL: begin
          divisor <= 23'(inertia) * 23'(r_depth);
          if (r_depth < mindep) mindep <= r_depth;
          state <= S_DIV;
        end
        S_DIV: state <= S_WAITD;
        S_WAITD: if (div_done) state <= S_SCORE;
        S_SCORE: begin
          score <= score_sat;
          if (op == afcs_pkg::OP_DROP && inertia != afcs_pkg::InertiaMax)
            inertia <= inertia + 16'd1;
          state <= S_RESZ;
        end
        S_RESZ: begin
          cap <= cap_next;
          if (fcount > cap_next) fcount <= cap_next;
          state <= (op == afcs_pkg::OP_DROP) ? S_OUT : S_STORE;
        end
        S_STORE: begin
          if (cap != 0) begin
            if (fcount < cap) begin
              tag_mem[4'(fhead + fcount[3:0])] <= tag;
              r_slot <= 4'(fhead + fcount[3:0]); fcount <= fcount + 5'd1;
            end else begin
              tag_mem[fhead] <= tag; r_slot <= fhead; fhead <= fhead + 4'd1;
            end
            r_stored <= 1'b1;
          end
          state <= S_OUT;
        end
        S_OUT: begin pend <= 1'b1; state <= S_IDLE; end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- design/afcs_div.sv -----
`default_nettype none
// Restoring divider: 1000 / divisor, one quotient bit per cycle.
module afcs_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [22:0] divisor,
  output logic             done,
  output logic [9:0]       quotient
);
  logic [4:0]  cnt;
  logic        busy;
  logic [9:0]  num;
  logic [23:0] rem;
  logic [23:0] trial;

  assign trial = {rem[22:0], num[9]} - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        cnt      <= 5'd10;
        num      <= 10'(afcs_pkg::ScoreUnit);
        rem      <= '0;
        quotient <= '0;
      end else if (busy) begin
        if (trial[23]) begin
          rem      <= {rem[22:0], num[9]};
          quotient <= {quotient[8:0], 1'b0};
        end else begin
          rem      <= trial;
          quotient <= {quotient[8:0], 1'b1};
        end
        num <= {num[8:0], 1'b0};
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire
